// ===== design/etss_pkg.sv =====
// Shared constants, types and state encoding for the eligibility trace sparse set.
package etss_pkg;

  localparam int FEATURES   = 4096;
  localparam int LIST_DEPTH = 1024;
  localparam int FEAT_W     = $clog2(FEATURES);
  localparam int LOC_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int VAL_W      = 16;

  localparam logic [VAL_W-1:0] ONE_Q15         = 16'd32768;
  localparam logic [11:0]      TENTH_Q15       = 12'd3277;
  localparam logic [VAL_W-1:0] MIN_TRACE_RESET = 16'd328;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_DECAY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_FETCH,
    ST_DECIDE,
    ST_RECHECK,
    ST_RAISE,
    ST_W_LIST,
    ST_W_TRACE,
    ST_W_EVAL,
    ST_W_MUL,
    ST_RM_A,
    ST_RM_B,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [FEAT_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [FEAT_W-1:0] raddr;
  } trace_port_t;

  typedef struct packed {
    logic              we;
    logic [LOC_W-1:0]  waddr;
    logic [FEAT_W-1:0] wdata;
    logic              re;
    logic [LOC_W-1:0]  raddr;
  } list_port_t;

  typedef struct packed {
    logic              we;
    logic [FEAT_W-1:0] waddr;
    logic [LOC_W-1:0]  wdata;
    logic              re;
    logic [FEAT_W-1:0] raddr;
  } pos_port_t;

endpackage

// ===== design/etss_ram.sv =====
// Simple dual-port synchronous RAM with a registered read.
module etss_ram #(
  parameter int W = 16,
  parameter int D = 1024
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/etss_ctrl.sv =====
// Sequencer that reads, modifies and writes back the trace, list and position memories.
module etss_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [etss_pkg::FEAT_W-1:0] feature,
  input  logic [etss_pkg::VAL_W-1:0]  amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [etss_pkg::CNT_W-1:0]  live_count,
  output logic [etss_pkg::VAL_W-1:0]  threshold,
  output logic                        threshold_raised,
  output etss_pkg::trace_port_t       trace_port,
  input  logic [etss_pkg::VAL_W-1:0]  trace_rdata,
  output etss_pkg::list_port_t        list_port,
  input  logic [etss_pkg::FEAT_W-1:0] list_rdata,
  output etss_pkg::pos_port_t         pos_port,
  input  logic [etss_pkg::LOC_W-1:0]  pos_rdata
);
  import etss_pkg::*;

  state_t            state, state_next;
  logic [1:0]        op_r;
  logic [FEAT_W-1:0] f_r;
  logic [VAL_W-1:0]  amt_r;
  logic [VAL_W-1:0]  min_r;
  logic [CNT_W-1:0]  total;
  logic [LOC_W-1:0]  loc;
  logic [FEAT_W-1:0] wf;
  logic [LOC_W-1:0]  rm_loc;
  logic [FEAT_W-1:0] rm_feat;
  logic              walking;
  logic              walk_decay;
  logic [31:0]       prod;
  logic              raised_r;
  logic [FEAT_W-1:0] wipe_cnt;

  logic              accept;
  logic              tv_nz, amt_lt, pos_in, full, min_sat, walk_last;
  logic              clear_branch, tv_lt, nv_lt;
  logic [VAL_W-1:0]  nv;
  logic [VAL_W-1:0]  amt_clamp;
  logic [27:0]       raise_prod;
  logic [VAL_W:0]    raise_sum;
  logic [VAL_W-1:0]  raise_next;
  logic [LOC_W-1:0]  last_loc;
  logic              step_go;
  state_t            step_state;

  assign accept       = in_valid && in_ready;
  assign in_ready     = (state == ST_IDLE);
  assign amt_clamp    = (amount > ONE_Q15) ? ONE_Q15 : amount;
  assign tv_nz        = (trace_rdata != '0);
  assign amt_lt       = (amt_r < min_r);
  assign pos_in       = (CNT_W'(pos_rdata) < total);
  assign full         = (total >= CNT_W'(LIST_DEPTH));
  assign min_sat      = (min_r == ONE_Q15);
  assign walk_last    = (loc == '0);
  assign clear_branch = ((op_r == OP_SET) && amt_lt) || (op_r == OP_CLEAR);
  assign tv_lt        = (trace_rdata < min_r);
  assign nv           = prod[30:15];
  assign nv_lt        = (nv < min_r);
  assign last_loc     = LOC_W'(total - CNT_W'(1));
  assign raise_prod   = 28'(min_r) * 28'(TENTH_Q15);
  assign raise_sum    = {1'b0, min_r} + (VAL_W+1)'(raise_prod[27:15]);
  assign raise_next   = (raise_sum > {1'b0, ONE_Q15}) ? ONE_Q15 : raise_sum[VAL_W-1:0];
  assign step_state   = walk_last ? (walk_decay ? ST_DONE : ST_RECHECK) : ST_W_LIST;

  // Next state.
  always_comb begin
    state_next = state;
    step_go    = 1'b0;
    case (state)
      ST_WIPE:    if (wipe_cnt == '1) state_next = ST_IDLE;
      ST_IDLE:    if (accept) state_next = ST_FETCH;
      ST_FETCH:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (clear_branch) begin
          state_next = (tv_nz && pos_in) ? ST_RM_A : ST_DONE;
        end else if (op_r == OP_SET) begin
          state_next = tv_nz ? ST_DONE : ST_RECHECK;
        end else if (op_r == OP_DECAY) begin
          state_next = (total == '0) ? ST_DONE : ST_W_LIST;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_RECHECK: state_next = (full && !min_sat) ? ST_RAISE : ST_DONE;
      ST_RAISE:   state_next = ST_W_LIST;
      ST_W_LIST:  state_next = ST_W_TRACE;
      ST_W_TRACE: state_next = ST_W_EVAL;
      ST_W_EVAL: begin
        if (walk_decay) begin
          state_next = ST_W_MUL;
        end else if (tv_lt) begin
          state_next = ST_RM_A;
        end else begin
          state_next = step_state;
          step_go    = 1'b1;
        end
      end
      ST_W_MUL: begin
        if (nv_lt) begin
          state_next = ST_RM_A;
        end else begin
          state_next = step_state;
          step_go    = 1'b1;
        end
      end
      ST_RM_A:    state_next = ST_RM_B;
      ST_RM_B: begin
        if (walking) begin
          state_next = step_state;
          step_go    = 1'b1;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:    state_next = ST_WIPE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    trace_port = '0;
    list_port  = '0;
    pos_port   = '0;
    case (state)
      ST_WIPE: begin
        trace_port.we    = 1'b1;
        trace_port.waddr = wipe_cnt;
      end
      ST_FETCH: begin
        trace_port.re    = 1'b1;
        trace_port.raddr = f_r;
        pos_port.re      = 1'b1;
        pos_port.raddr   = f_r;
      end
      ST_DECIDE: begin
        trace_port.waddr = f_r;
        if (clear_branch) begin
          trace_port.we = tv_nz && !pos_in;
        end else if (op_r == OP_SET) begin
          trace_port.we    = tv_nz;
          trace_port.wdata = amt_r;
        end
      end
      ST_RECHECK: begin
        if (!full && !amt_lt) begin
          trace_port.we    = 1'b1;
          trace_port.waddr = f_r;
          trace_port.wdata = amt_r;
          list_port.we     = 1'b1;
          list_port.waddr  = LOC_W'(total);
          list_port.wdata  = f_r;
          pos_port.we      = 1'b1;
          pos_port.waddr   = f_r;
          pos_port.wdata   = LOC_W'(total);
        end
      end
      ST_W_LIST: begin
        list_port.re    = 1'b1;
        list_port.raddr = loc;
      end
      ST_W_TRACE: begin
        trace_port.re    = 1'b1;
        trace_port.raddr = list_rdata;
      end
      ST_W_MUL: begin
        trace_port.we    = !nv_lt;
        trace_port.waddr = wf;
        trace_port.wdata = nv;
      end
      ST_RM_A: begin
        trace_port.we    = 1'b1;
        trace_port.waddr = rm_feat;
        list_port.re     = 1'b1;
        list_port.raddr  = last_loc;
      end
      ST_RM_B: begin
        list_port.we    = 1'b1;
        list_port.waddr = rm_loc;
        list_port.wdata = list_rdata;
        pos_port.we     = 1'b1;
        pos_port.waddr  = list_rdata;
        pos_port.wdata  = rm_loc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_WIPE;
      wipe_cnt  <= '0;
      total     <= '0;
      min_r     <= MIN_TRACE_RESET;
      out_valid <= 1'b0;
      raised_r  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_WIPE) begin
        wipe_cnt <= wipe_cnt + FEAT_W'(1);
      end
      if (accept) begin
        op_r     <= operation;
        f_r      <= feature;
        amt_r    <= amt_clamp;
        raised_r <= 1'b0;
      end
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_DECIDE: begin
          rm_loc     <= pos_rdata;
          rm_feat    <= f_r;
          walking    <= 1'b0;
          walk_decay <= 1'b1;
          loc        <= last_loc;
        end
        ST_RECHECK: begin
          if (!(full && !min_sat) && !full && !amt_lt) begin
            total <= total + CNT_W'(1);
          end
        end
        ST_RAISE: begin
          min_r      <= raise_next;
          raised_r   <= 1'b1;
          loc        <= last_loc;
          walking    <= 1'b1;
          walk_decay <= 1'b0;
        end
        ST_W_TRACE: begin
          wf <= list_rdata;
        end
        ST_W_EVAL: begin
          prod    <= 32'(trace_rdata) * 32'(amt_r);
          rm_loc  <= loc;
          rm_feat <= wf;
          walking <= 1'b1;
        end
        ST_W_MUL: begin
          rm_loc  <= loc;
          rm_feat <= wf;
        end
        ST_RM_A: begin
          total <= total - CNT_W'(1);
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid        <= 1'b1;
            live_count       <= total;
            threshold        <= min_r;
            threshold_raised <= raised_r;
          end
        end
        default: begin
        end
      endcase
      if (step_go) begin
        loc <= loc - LOC_W'(1);
      end
    end
  end

endmodule

// ===== design/eligibility_trace_sparse_set_unit.sv =====
// Top level of the eligibility trace sparse set: memories, sequencer and checks.
//
// The block keeps a Q1.15 trace for each of 4096 features in a trace memory, a
// compact list of the live features in a 1024-entry list memory, and each live
// feature's list position in a position memory. One request is worked on at a
// time and gives exactly one result; the result register lets the next request
// be taken while a result still waits. After reset the trace memory is swept to
// zero, one entry per cycle, so no request is accepted until all 4096 entries
// are clear. Memory reads are registered, so each request steps in sequence
// through fetch and decide and, where needed, insert, removal or walk states.
// A decay walks every live list entry, keeping or removing each one. A set on
// a full list raises the threshold and culls the whole list, repeated for each
// raise until a slot frees or the threshold reaches 1.0.
module eligibility_trace_sparse_set_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  operation,
  input  logic [etss_pkg::FEAT_W-1:0] feature,
  input  logic [etss_pkg::VAL_W-1:0]  amount,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [etss_pkg::CNT_W-1:0]  live_count,
  output logic [etss_pkg::VAL_W-1:0]  threshold,
  output logic                        threshold_raised
);
  import etss_pkg::*;

  trace_port_t       trace_port;
  list_port_t        list_port;
  pos_port_t         pos_port;
  logic [VAL_W-1:0]  trace_rdata;
  logic [FEAT_W-1:0] list_rdata;
  logic [LOC_W-1:0]  pos_rdata;

  // Trace value per feature; cleared by the sweep after reset.
  etss_ram #(.W(VAL_W), .D(FEATURES)) u_trace (
    .clk   (clk),
    .we    (trace_port.we),
    .waddr (trace_port.waddr),
    .wdata (trace_port.wdata),
    .re    (trace_port.re),
    .raddr (trace_port.raddr),
    .rdata (trace_rdata)
  );

  // Compact list of live features; only entries below the live count are read.
  etss_ram #(.W(FEAT_W), .D(LIST_DEPTH)) u_list (
    .clk   (clk),
    .we    (list_port.we),
    .waddr (list_port.waddr),
    .wdata (list_port.wdata),
    .re    (list_port.re),
    .raddr (list_port.raddr),
    .rdata (list_rdata)
  );

  // Inverse map from feature to list position, valid only for live features.
  etss_ram #(.W(LOC_W), .D(FEATURES)) u_pos (
    .clk   (clk),
    .we    (pos_port.we),
    .waddr (pos_port.waddr),
    .wdata (pos_port.wdata),
    .re    (pos_port.re),
    .raddr (pos_port.raddr),
    .rdata (pos_rdata)
  );

  etss_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .feature          (feature),
    .amount           (amount),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .live_count       (live_count),
    .threshold        (threshold),
    .threshold_raised (threshold_raised),
    .trace_port       (trace_port),
    .trace_rdata      (trace_rdata),
    .list_port        (list_port),
    .list_rdata       (list_rdata),
    .pos_port         (pos_port),
    .pos_rdata        (pos_rdata)
  );

  // The live count reported never exceeds the list capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (live_count <= CNT_W'(LIST_DEPTH)))
    else $error("live count above list depth");

  // The threshold never passes 1.0, and a raise always leaves it above its reset value.
  a_thresh_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (threshold <= ONE_Q15) &&
                  (!threshold_raised || (threshold > MIN_TRACE_RESET)))
    else $error("threshold out of range");

  // Every write to the list memory comes with a write to the position memory.
  a_list_pos_pair: assert property (@(posedge clk) disable iff (rst)
    list_port.we |-> pos_port.we)
    else $error("list written without position update");

endmodule
